/* sv/hcr_pkg.sv */
// hcr_pkg: shared constants for the hsv / cmyk to rgb converter
// no dependencies; used by the converter top level
`timescale 1ns / 1ps
`default_nettype none

package hcr_pkg;

    // operation codes carried on func
    localparam logic [1:0] FUNC_HSV  = 2'd0;
    localparam logic [1:0] FUNC_CMYK = 2'd1;
    localparam logic [1:0] FUNC_RGB  = 2'd2;

    localparam logic [5:0]  DEG_PER_SECTOR = 6'd60;
    localparam logic [15:0] HUE_FULL       = 16'd360;
    localparam logic [7:0]  CHAN_MAX       = 8'd255;

    // floor(y / 60) == (y * RECIP_DIV60) >> RECIP_SHIFT for y < 2**Y_BITS
    localparam int unsigned Y_BITS      = 14;
    localparam logic [14:0] RECIP_DIV60 = 15'd17477;
    localparam int unsigned RECIP_SHIFT = 20;

    // sequencer state codes
    typedef logic [2:0] state_t;
    localparam state_t S_IDLE = 3'd0;
    localparam state_t S_MU   = 3'd1;
    localparam state_t S_W    = 3'd2;
    localparam state_t S_MV   = 3'd3;
    localparam state_t S_Y    = 3'd4;
    localparam state_t S_MK   = 3'd5;
    localparam state_t S_Q    = 3'd6;
    localparam state_t S_DONE = 3'd7;

endpackage

`default_nettype wire

/* sv/hcr_mul.sv */
// hcr_mul: shared unsigned multiplier with a registered product
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module hcr_mul #(
    parameter int unsigned A_WIDTH = 17,
    parameter int unsigned B_WIDTH = 22
) (
    input  wire logic                         clk,
    input  wire logic [A_WIDTH-1:0]           a,
    input  wire logic [B_WIDTH-1:0]           b,
    output logic      [A_WIDTH+B_WIDTH-1:0]   p
);

    logic [A_WIDTH+B_WIDTH-1:0] p_reg;
    logic [A_WIDTH+B_WIDTH-1:0] p_next;

    assign p_next = {{B_WIDTH{1'b0}}, a} * {{A_WIDTH{1'b0}}, b};

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* sv/hsv_cmyk_to_rgb_converter_unit.sv */
// hsv / cmyk to rgb converter top level, depends on hcr_pkg and hcr_mul
// sequence: a direct load or rejected request goes straight to S_DONE, which loads the result register;
//   an hsv or cmyk conversion runs S_MU, S_W, S_MV, S_Y, S_MK, S_Q per channel on one shared multiplier, then S_DONE
// flow: a new request is not taken until the previous one has loaded its result;
//   req_ready is high only while the sequencer is idle, a held result stalls the sequencer in S_DONE
// reset: asynchronous active-low rst_n clears the current color to black, empties the result
`timescale 1ns / 1ps
`default_nettype none

module hsv_cmyk_to_rgb_converter_unit #(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [1:0]         func,
    input  wire logic [15:0]        hue,
    input  wire logic signed [10:0] saturation,
    input  wire logic signed [10:0] brightness,
    input  wire logic signed [10:0] cyan,
    input  wire logic signed [10:0] magenta,
    input  wire logic signed [10:0] yellow,
    input  wire logic signed [10:0] black_level,
    input  wire logic [7:0]         red_in,
    input  wire logic [7:0]         green_in,
    input  wire logic [7:0]         blue_in,
    // result channel
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic                    accepted
);

    // every channel reduces to floor(vv * (60*one - a*u) * 255 / (60 * one**2)):
    //   hsv:  vv = value, a = saturation, u = 0 (C), 60-t (X) or 60 (zero channel)
    //   cmyk: vv = one - key, a = colour fraction, u = 60
    // the floor is split into a shift by 2*FRACTION_BITS and a reciprocal divide by 60

    localparam int unsigned F  = FRACTION_BITS;
    localparam int unsigned VW = F + 1;                 // fraction 0..one
    localparam int unsigned WW = F + 6;                 // 60*one - a*u
    localparam int unsigned YW = hcr_pkg::Y_BITS;
    localparam int unsigned MA = (VW > YW) ? VW : YW;   // multiplier operand a
    localparam int unsigned MB = (WW > 15) ? WW : 15;   // multiplier operand b
    localparam int unsigned PW = MA + MB;

    localparam logic [VW-1:0] ONE    = VW'(1) << F;
    localparam logic [WW-1:0] W_FULL = WW'(hcr_pkg::DEG_PER_SECTOR) << F;

    function automatic logic frac_ok(input logic [10:0] x);
        frac_ok = !x[10] && ({22'd0, x[9:0]} <= 32'(ONE));
    endfunction

    // ---------------------------------------------------------------- state
    hcr_pkg::state_t state_reg, state_next;
    logic [1:0]      ch_reg, ch_next;
    logic            res_valid_reg, res_valid_next;
    logic [7:0]      cur_red_reg, cur_red_next;
    logic [7:0]      cur_green_reg, cur_green_next;
    logic [7:0]      cur_blue_reg, cur_blue_next;

    // per-request working registers
    logic [VW-1:0]   a_reg [3];
    logic [VW-1:0]   a_next [3];
    logic [5:0]      u_reg [3];
    logic [5:0]      u_next [3];
    logic [VW-1:0]   vv_reg, vv_next;
    logic [WW-1:0]   w_reg, w_next;
    logic [YW-1:0]   y_reg, y_next;
    logic            ok_reg, ok_next;

    // result register
    logic [7:0]      res_red_reg, res_red_next;
    logic [7:0]      res_green_reg, res_green_next;
    logic [7:0]      res_blue_reg, res_blue_next;
    logic            res_ok_reg, res_ok_next;

    // shared multiplier
    logic [MA-1:0]   mul_a;
    logic [MB-1:0]   mul_b;
    logic [PW-1:0]   prod;

    hcr_mul #(
        .A_WIDTH (MA),
        .B_WIDTH (MB)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // ---------------------------------------------------------- hue decode
    logic [8:0] h_deg;
    logic [2:0] sector;
    logic [8:0] sector_base;
    logic [5:0] hue_frac;
    logic [5:0] ux;

    always_comb
    begin
        // 360 wraps to red
        h_deg = (hue == hcr_pkg::HUE_FULL) ? 9'd0 : hue[8:0];
        if (h_deg >= 9'(5 * hcr_pkg::DEG_PER_SECTOR))
            sector = 3'd5;
        else if (h_deg >= 9'(4 * hcr_pkg::DEG_PER_SECTOR))
            sector = 3'd4;
        else if (h_deg >= 9'(3 * hcr_pkg::DEG_PER_SECTOR))
            sector = 3'd3;
        else if (h_deg >= 9'(2 * hcr_pkg::DEG_PER_SECTOR))
            sector = 3'd2;
        else if (h_deg >= 9'(hcr_pkg::DEG_PER_SECTOR))
            sector = 3'd1;
        else
            sector = 3'd0;

        case (sector)
            3'd1:    sector_base = 9'(hcr_pkg::DEG_PER_SECTOR);
            3'd2:    sector_base = 9'(2 * hcr_pkg::DEG_PER_SECTOR);
            3'd3:    sector_base = 9'(3 * hcr_pkg::DEG_PER_SECTOR);
            3'd4:    sector_base = 9'(4 * hcr_pkg::DEG_PER_SECTOR);
            3'd5:    sector_base = 9'(5 * hcr_pkg::DEG_PER_SECTOR);
            default: sector_base = 9'd0;
        endcase

        hue_frac = 6'(h_deg - sector_base);
        // weight of the X channel: 60 - t, with t = f on even sectors, 60 - f on odd
        ux = sector[0] ? hue_frac : 6'(hcr_pkg::DEG_PER_SECTOR - hue_frac);
    end

    // ------------------------------------------------------ datapath taps
    logic [PW+7:0] scaled;     // prod * 255
    logic [8:0]    quot;
    logic [7:0]    chan_byte;

    assign scaled    = {prod, 8'd0} - {8'd0, prod};
    assign quot      = prod[hcr_pkg::RECIP_SHIFT+8:hcr_pkg::RECIP_SHIFT];
    assign chan_byte = quot[8] ? hcr_pkg::CHAN_MAX : quot[7:0];

    assign req_ready = (state_reg == hcr_pkg::S_IDLE);

    // ---------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        cur_red_next   = cur_red_reg;
        cur_green_next = cur_green_reg;
        cur_blue_next  = cur_blue_reg;
        a_next         = a_reg;
        u_next         = u_reg;
        vv_next        = vv_reg;
        w_next         = w_reg;
        y_next         = y_reg;
        ok_next        = ok_reg;
        res_red_next   = res_red_reg;
        res_green_next = res_green_reg;
        res_blue_next  = res_blue_reg;
        res_ok_next    = res_ok_reg;
        res_valid_next = res_valid_reg && !res_ready;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            hcr_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    ch_next = 2'd0;
                    case (func)
                        hcr_pkg::FUNC_HSV:
                        begin
                            vv_next   = VW'(brightness[9:0]);
                            a_next[0] = VW'(saturation[9:0]);
                            a_next[1] = VW'(saturation[9:0]);
                            a_next[2] = VW'(saturation[9:0]);
                            // (r,g,b) weights per sector: C gets 0, X gets ux, zero gets 60
                            case (sector)
                                3'd0:
                                begin
                                    u_next[0] = 6'd0;
                                    u_next[1] = ux;
                                    u_next[2] = hcr_pkg::DEG_PER_SECTOR;
                                end
                                3'd1:
                                begin
                                    u_next[0] = ux;
                                    u_next[1] = 6'd0;
                                    u_next[2] = hcr_pkg::DEG_PER_SECTOR;
                                end
                                3'd2:
                                begin
                                    u_next[0] = hcr_pkg::DEG_PER_SECTOR;
                                    u_next[1] = 6'd0;
                                    u_next[2] = ux;
                                end
                                3'd3:
                                begin
                                    u_next[0] = hcr_pkg::DEG_PER_SECTOR;
                                    u_next[1] = ux;
                                    u_next[2] = 6'd0;
                                end
                                3'd4:
                                begin
                                    u_next[0] = ux;
                                    u_next[1] = hcr_pkg::DEG_PER_SECTOR;
                                    u_next[2] = 6'd0;
                                end
                                default:
                                begin
                                    u_next[0] = 6'd0;
                                    u_next[1] = hcr_pkg::DEG_PER_SECTOR;
                                    u_next[2] = ux;
                                end
                            endcase
                            if (hue <= hcr_pkg::HUE_FULL && frac_ok(saturation)
                                && frac_ok(brightness))
                            begin
                                ok_next    = 1'b1;
                                state_next = hcr_pkg::S_MU;
                            end
                            else
                            begin
                                ok_next    = 1'b0;
                                state_next = hcr_pkg::S_DONE;
                            end
                        end
                        hcr_pkg::FUNC_CMYK:
                        begin
                            vv_next   = ONE - VW'(black_level[9:0]);
                            a_next[0] = VW'(cyan[9:0]);
                            a_next[1] = VW'(magenta[9:0]);
                            a_next[2] = VW'(yellow[9:0]);
                            u_next[0] = hcr_pkg::DEG_PER_SECTOR;
                            u_next[1] = hcr_pkg::DEG_PER_SECTOR;
                            u_next[2] = hcr_pkg::DEG_PER_SECTOR;
                            if (frac_ok(cyan) && frac_ok(magenta) && frac_ok(yellow)
                                && frac_ok(black_level))
                            begin
                                ok_next    = 1'b1;
                                state_next = hcr_pkg::S_MU;
                            end
                            else
                            begin
                                ok_next    = 1'b0;
                                state_next = hcr_pkg::S_DONE;
                            end
                        end
                        hcr_pkg::FUNC_RGB:
                        begin
                            cur_red_next   = red_in;
                            cur_green_next = green_in;
                            cur_blue_next  = blue_in;
                            ok_next        = 1'b1;
                            state_next     = hcr_pkg::S_DONE;
                        end
                        default:
                        begin
                            // unused selector, color kept
                            ok_next    = 1'b0;
                            state_next = hcr_pkg::S_DONE;
                        end
                    endcase
                end
            end

            hcr_pkg::S_MU:
            begin
                mul_a      = MA'(a_reg[ch_reg]);
                mul_b      = MB'(u_reg[ch_reg]);
                state_next = hcr_pkg::S_W;
            end

            hcr_pkg::S_W:
            begin
                w_next     = W_FULL - prod[WW-1:0];
                state_next = hcr_pkg::S_MV;
            end

            hcr_pkg::S_MV:
            begin
                mul_a      = MA'(vv_reg);
                mul_b      = MB'(w_reg);
                state_next = hcr_pkg::S_Y;
            end

            hcr_pkg::S_Y:
            begin
                // floor(prod * 255 / one**2)
                y_next     = scaled[2*F+YW-1:2*F];
                state_next = hcr_pkg::S_MK;
            end

            hcr_pkg::S_MK:
            begin
                mul_a      = MA'(y_reg);
                mul_b      = MB'(hcr_pkg::RECIP_DIV60);
                state_next = hcr_pkg::S_Q;
            end

            hcr_pkg::S_Q:
            begin
                case (ch_reg)
                    2'd0:    cur_red_next   = chan_byte;
                    2'd1:    cur_green_next = chan_byte;
                    default: cur_blue_next  = chan_byte;
                endcase
                if (ch_reg == 2'd2)
                    state_next = hcr_pkg::S_DONE;
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = hcr_pkg::S_MU;
                end
            end

            hcr_pkg::S_DONE:
            begin
                // wait for the result register to free up
                if (!res_valid_reg || res_ready)
                begin
                    res_red_next   = cur_red_reg;
                    res_green_next = cur_green_reg;
                    res_blue_next  = cur_blue_reg;
                    res_ok_next    = ok_reg;
                    res_valid_next = 1'b1;
                    state_next     = hcr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = hcr_pkg::S_IDLE;
            end
        endcase
    end

    // control and color state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcr_pkg::S_IDLE;
            ch_reg        <= 2'd0;
            res_valid_reg <= 1'b0;
            cur_red_reg   <= 8'd0;
            cur_green_reg <= 8'd0;
            cur_blue_reg  <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            res_valid_reg <= res_valid_next;
            cur_red_reg   <= cur_red_next;
            cur_green_reg <= cur_green_next;
            cur_blue_reg  <= cur_blue_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        u_reg         <= u_next;
        vv_reg        <= vv_next;
        w_reg         <= w_next;
        y_reg         <= y_next;
        ok_reg        <= ok_next;
        res_red_reg   <= res_red_next;
        res_green_reg <= res_green_next;
        res_blue_reg  <= res_blue_next;
        res_ok_reg    <= res_ok_next;
    end

    assign res_valid = res_valid_reg;
    assign red       = res_red_reg;
    assign green     = res_green_reg;
    assign blue      = res_blue_reg;
    assign accepted  = res_ok_reg;

endmodule

`default_nettype wire
